// File: design/mhodr_pkg.sv
// Package for the three-zone mho distance relay.
// Payload structs, sequencer states, register indexes and sizing constants.
`default_nettype none
package mhodr_pkg;

  localparam int NumPhasesDefault = 3;
  localparam int ZoneCount        = 3;
  localparam int RegAddrWidth     = 5;

  // Register indexes, byte address is 4 * index
  localparam logic [2:0] REG_Z1_REACH = 3'd0;
  localparam logic [2:0] REG_Z2_REACH = 3'd1;
  localparam logic [2:0] REG_Z3_REACH = 3'd2;
  localparam logic [2:0] REG_Z1_DELAY = 3'd3;
  localparam logic [2:0] REG_Z2_DELAY = 3'd4;
  localparam logic [2:0] REG_Z3_DELAY = 3'd5;

  typedef struct packed {
    logic [1:0]         phase_index;
    logic signed [15:0] voltage_re;
    logic signed [15:0] voltage_im;
    logic signed [15:0] current_re;
    logic signed [15:0] current_im;
    logic [31:0]        now_time;
    logic [31:0]        fault_start;
  } mhodr_in_t;

  typedef struct packed {
    logic [2:0] trip_flags;
    logic [2:0] zones_operated;
  } mhodr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_DOT_RE,
    ST_DOT_IM,
    ST_DOT_SUM,
    ST_ZONE_MUL,
    ST_ZONE_CMP,
    ST_DONE
  } mhodr_state_t;

endpackage
`default_nettype wire

// File: design/mho_distance_relay_three_zone.sv
// Top level of the three-zone mho distance relay.
// Depends on mhodr_pkg for payload structs, states and register indexes.
//
// Each item is worked through in turn: a single 17 x 33 signed multiplier is
// reused under a small sequencer for the two squares, the two dot-product
// terms and one reach product per zone, each zone also taking a compare step.
// The input is not ready from the transfer until the result is loaded into
// the output register; a result may still wait there while the next item is
// taken. The circle test is exact: 256 * |U|^2 < reach * Re(U conj I). Trip
// flags are sticky and cleared only by reset.
`default_nettype none
module mho_distance_relay_three_zone #(
  parameter int NUM_PHASES = mhodr_pkg::NumPhasesDefault
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  mhodr_pkg::mhodr_in_t              in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output mhodr_pkg::mhodr_out_t             out_data,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [mhodr_pkg::RegAddrWidth-1:0] paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import mhodr_pkg::*;

  mhodr_state_t       state_r, state_nxt;
  mhodr_in_t          item_r;
  logic [15:0]        reach_r [ZoneCount];
  logic [31:0]        delay_r [ZoneCount];
  logic [NUM_PHASES-1:0] trip_r;
  logic [1:0]         zone_r;
  logic [2:0]         zones_r;
  logic signed [49:0] prod_r;
  logic [31:0]        mag_r;
  logic signed [32:0] dot_r;
  logic signed [32:0] elapsed_r;
  logic               out_valid_r;
  mhodr_out_t         out_data_r;

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] mul_p;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               zone_hit;
  logic [NUM_PHASES-1:0] trip_set;
  logic [2:0]         flags_nxt;
  logic               load_out;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int z = 0; z < ZoneCount; z++) begin
        reach_r[z] <= '0;
        delay_r[z] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_Z1_REACH: reach_r[0] <= pwdata[15:0];
        REG_Z2_REACH: reach_r[1] <= pwdata[15:0];
        REG_Z3_REACH: reach_r[2] <= pwdata[15:0];
        REG_Z1_DELAY: delay_r[0] <= pwdata;
        REG_Z2_DELAY: delay_r[1] <= pwdata;
        REG_Z3_DELAY: delay_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_Z1_REACH: prdata = {16'd0, reach_r[0]};
      REG_Z2_REACH: prdata = {16'd0, reach_r[1]};
      REG_Z3_REACH: prdata = {16'd0, reach_r[2]};
      REG_Z1_DELAY: prdata = delay_r[0];
      REG_Z2_DELAY: prdata = delay_r[1];
      REG_Z3_DELAY: prdata = delay_r[2];
      default:      prdata = '0;
    endcase
  end

  // Shared multiplier operand selection
  always_comb begin
    unique case (state_r)
      ST_SQ_RE: begin
        mul_a = {item_r.voltage_re[15], item_r.voltage_re};
        mul_b = {{17{item_r.voltage_re[15]}}, item_r.voltage_re};
      end
      ST_SQ_IM: begin
        mul_a = {item_r.voltage_im[15], item_r.voltage_im};
        mul_b = {{17{item_r.voltage_im[15]}}, item_r.voltage_im};
      end
      ST_DOT_RE: begin
        mul_a = {item_r.voltage_re[15], item_r.voltage_re};
        mul_b = {{17{item_r.current_re[15]}}, item_r.current_re};
      end
      ST_DOT_IM: begin
        mul_a = {item_r.voltage_im[15], item_r.voltage_im};
        mul_b = {{17{item_r.current_im[15]}}, item_r.current_im};
      end
      ST_ZONE_MUL: begin
        mul_a = {1'b0, reach_r[zone_r]};
        mul_b = dot_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Zone operates when strictly late and strictly inside the circle
  assign zone_hit = ($signed(elapsed_r) > $signed({1'b0, delay_r[zone_r]})) &&
                    ($signed({10'd0, mag_r, 8'd0}) < prod_r);

  always_comb begin
    for (int p = 0; p < NUM_PHASES; p++) begin
      trip_set[p] = (item_r.phase_index == 2'(p)) && (zones_r != 3'd0);
    end
    for (int p = 0; p < 3; p++) begin
      flags_nxt[p] = 1'b0;
      if (p < NUM_PHASES) begin
        flags_nxt[p] = trip_r[p] | trip_set[p];
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SQ_RE;
        end
      end
      ST_SQ_RE:    state_nxt = ST_SQ_IM;
      ST_SQ_IM:    state_nxt = ST_DOT_RE;
      ST_DOT_RE:   state_nxt = ST_DOT_IM;
      ST_DOT_IM:   state_nxt = ST_DOT_SUM;
      ST_DOT_SUM:  state_nxt = ST_ZONE_MUL;
      ST_ZONE_MUL: state_nxt = ST_ZONE_CMP;
      ST_ZONE_CMP: begin
        if (zone_r == 2'(ZoneCount - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ZONE_MUL;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r != ST_IDLE && state_r != ST_DONE) begin
      prod_r <= mul_p;
    end
    unique case (state_r)
      ST_SQ_RE:   elapsed_r <= $signed({1'b0, item_r.now_time}) -
                               $signed({1'b0, item_r.fault_start});
      ST_SQ_IM:   mag_r <= prod_r[31:0];
      ST_DOT_RE:  mag_r <= mag_r + prod_r[31:0];
      ST_DOT_IM:  dot_r <= prod_r[32:0];
      ST_DOT_SUM: dot_r <= dot_r + prod_r[32:0];
      default: ;
    endcase
    if (load_out) begin
      out_data_r.trip_flags     <= flags_nxt;
      out_data_r.zones_operated <= (item_r.phase_index < 2'(NUM_PHASES)) ? zones_r : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r      <= '0;
      zones_r     <= '0;
      trip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        zone_r  <= '0;
        zones_r <= '0;
      end else if (state_r == ST_ZONE_CMP) begin
        zones_r[zone_r] <= zone_hit;
        zone_r          <= zone_r + 2'd1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        trip_r      <= trip_r | trip_set;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown without finishing an item");

  a_trip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 ((trip_r & $past(trip_r)) == $past(trip_r)))
    else $error("trip flag cleared outside reset");

  a_zone_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ZONE_MUL || state_r == ST_ZONE_CMP) |-> (zone_r < 2'(ZoneCount)))
    else $error("zone counter out of range");

  a_zone_trips: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.zones_operated != 3'd0) |-> (out_data_r.trip_flags != 3'd0))
    else $error("operated zone without trip flag");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the three-zone mho distance relay.
// Needs mhodr_pkg and mho_distance_relay_three_zone; predicts every result
// in a local model of the zones and trip flags, and drives the APB-style port.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mhodr_pkg::*;

  localparam int NumPhases = NumPhasesDefault;
  // indexes past the register list, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [15:0] S16_MAX = 16'h7FFF;
  localparam logic [15:0] S16_MIN = 16'h8000;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  mhodr_in_t in_data;
  logic out_valid;
  logic out_ready;
  mhodr_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [RegAddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] reach_cfg [ZoneCount];
  logic [31:0] delay_cfg [ZoneCount];
  logic trip_state [NumPhases];
  mhodr_out_t expected_trips [$];
  int mismatches = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  mho_distance_relay_three_zone #(
    .NUM_PHASES(NumPhases)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Zone decisions and sticky flags for one accepted item.
  function automatic mhodr_out_t predict_relay(input mhodr_in_t it);
    mhodr_out_t res;
    longint ur, ui, ir, ii, now_t, start_t, elapsed, lhs, dot, rc, dl;
    ur = longint'(it.voltage_re);
    ui = longint'(it.voltage_im);
    ir = longint'(it.current_re);
    ii = longint'(it.current_im);
    now_t = longint'(it.now_time);
    start_t = longint'(it.fault_start);
    elapsed = now_t - start_t;
    lhs = 256 * (ur * ur + ui * ui);
    dot = ur * ir + ui * ii;
    res = '0;
    if (it.phase_index < NumPhases) begin
      for (int z = 0; z < ZoneCount; z++) begin
        rc = longint'(reach_cfg[z]);
        dl = longint'(delay_cfg[z]);
        if (elapsed > dl && lhs < rc * dot) res.zones_operated[z] = 1'b1;
      end
      if (res.zones_operated != 3'b000) trip_state[it.phase_index] = 1'b1;
    end
    for (int p = 0; p < NumPhases; p++) res.trip_flags[p] = trip_state[p];
    return res;
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v > 32767) return S16_MAX;
    if (v < -32768) return S16_MIN;
    return v[15:0];
  endfunction

  function automatic mhodr_in_t make_item(input logic [1:0] ph, input logic [15:0] ur,
                                          input logic [15:0] ui, input logic [15:0] ir,
                                          input logic [15:0] ii, input logic [31:0] now_t,
                                          input logic [31:0] start_t);
    mhodr_in_t it;
    it.phase_index = ph;
    it.voltage_re = ur;
    it.voltage_im = ui;
    it.current_re = ir;
    it.current_im = ii;
    it.now_time = now_t;
    it.fault_start = start_t;
    return it;
  endfunction

  // Voltage placed near one zone's circle: U = k * (f + jp) / 131072 * I,
  // inside when f*f + p*p < 512*f; elapsed time mostly near a random zone's delay.
  function automatic mhodr_in_t make_fault_item();
    mhodr_in_t it;
    int z;
    longint ir, ii, f, p, k, ur, ui, dl, delta;
    z = $urandom_range(0, ZoneCount - 1);
    it.phase_index = 2'($urandom_range(0, NumPhases - 1));
    if ($urandom_range(0, 1) != 0) begin
      it.current_re = 16'($urandom);
      it.current_im = 16'($urandom);
    end else begin
      ir = longint'($urandom_range(0, 2000));
      ii = longint'($urandom_range(0, 2000));
      ir = ir - 1000;
      ii = ii - 1000;
      it.current_re = ir[15:0];
      it.current_im = ii[15:0];
    end
    ir = longint'(it.current_re);
    ii = longint'(it.current_im);
    f = longint'($urandom_range(0, 320));
    p = longint'($urandom_range(0, 160));
    p = p - 80;
    k = longint'(reach_cfg[z]);
    ur = ((ir * f - ii * p) * k) / 131072;
    ui = ((ii * f + ir * p) * k) / 131072;
    it.voltage_re = sat16(ur);
    it.voltage_im = sat16(ui);
    if ($urandom_range(0, 4) == 0) begin
      delta = longint'($urandom);
    end else begin
      dl = longint'(delay_cfg[$urandom_range(0, ZoneCount - 1)]);
      delta = dl + longint'($urandom_range(0, 6));
      delta = delta - 3;
    end
    it.now_time = $urandom;
    it.fault_start = it.now_time - delta[31:0];
    return it;
  endfunction

  function automatic mhodr_in_t make_noise_item();
    mhodr_in_t it;
    it.phase_index = 2'($urandom_range(0, 3));
    it.voltage_re = 16'($urandom);
    it.voltage_im = 16'($urandom);
    it.current_re = 16'($urandom);
    it.current_im = 16'($urandom);
    it.now_time = $urandom;
    it.fault_start = $urandom;
    return it;
  endfunction

  // Valid stays high after the transfer; the next call either reuses it or drops it.
  task automatic send_item(input mhodr_in_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_trips.push_back(predict_relay(it));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_trips.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    unique case (idx)
      REG_Z1_REACH: reach_cfg[0] = value[15:0];
      REG_Z2_REACH: reach_cfg[1] = value[15:0];
      REG_Z3_REACH: reach_cfg[2] = value[15:0];
      REG_Z1_DELAY: delay_cfg[0] = value;
      REG_Z2_DELAY: delay_cfg[1] = value;
      REG_Z3_DELAY: delay_cfg[2] = value;
      default: ;
    endcase
    // hold the bus idle between writes
    @(posedge clk);
  endtask

  // Result sink: random stall before each transfer while rx_idle is set.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_results
    mhodr_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_trips.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = expected_trips.pop_front();
        if (out_data.trip_flags !== want.trip_flags) begin
          $display("%0t: trip_flags mismatch, expected %b actual %b",
                   $time, want.trip_flags, out_data.trip_flags);
          mismatches++;
        end
        if (out_data.zones_operated !== want.zones_operated) begin
          $display("%0t: zones_operated mismatch, expected %b actual %b",
                   $time, want.zones_operated, out_data.zones_operated);
          mismatches++;
        end
      end
    end
  end

  // Registers still at reset: no zone may operate however large the inputs.
  task automatic test_zero_reach();
    send_item(make_item(2'd0, S16_MIN, S16_MIN, S16_MAX, S16_MAX, U32_MAX, 32'd0));
    send_item(make_item(2'd1, 16'd1, 16'd0, 16'd2, 16'd0, 32'd1000, 32'd0));
    wait_results_done();
  endtask

  task automatic test_register_map();
    set_reg(REG_Z1_REACH, 32'h0000_0200);
    set_reg(REG_Z2_REACH, 32'hABCD_0400);
    set_reg(REG_Z3_REACH, 32'h0000_FFFF);
    set_reg(REG_Z1_DELAY, 32'd10);
    set_reg(REG_Z2_DELAY, 32'd100);
    set_reg(REG_Z3_DELAY, 32'd1000);
    set_reg(REG_SPARE_LO, U32_MAX);
    set_reg(REG_SPARE_HI, 32'h1234_5678);
  endtask

  // Phase index past the last phase: no zones, flags untouched.
  task automatic test_phase_out_of_range();
    send_item(make_item(2'd3, 16'd3, 16'd0, 16'd2, 16'd0, 32'd5000, 32'd0));
    send_item(make_item(2'd3, 16'd3, 16'd3, 16'd2, 16'd2, U32_MAX, 32'd0));
    wait_results_done();
  endtask

  task automatic test_elapsed_edges();
    // equal to the zone one delay must not operate
    send_item(make_item(2'd0, 16'd3, 16'd0, 16'd2, 16'd0, 32'd110, 32'd100));
    send_item(make_item(2'd0, 16'd3, 16'd0, 16'd2, 16'd0, 32'd111, 32'd100));
    // fault start after now gives a negative elapsed time
    send_item(make_item(2'd1, 16'd3, 16'd0, 16'd2, 16'd0, 32'd100, 32'd200));
    send_item(make_item(2'd1, 16'd3, 16'd0, 16'd2, 16'd0, 32'd0, U32_MAX));
    send_item(make_item(2'd1, 16'd3, 16'd0, 16'd2, 16'd0, U32_MAX, 32'd0));
    wait_results_done();
  endtask

  task automatic test_circle_boundary();
    // on the zone one circle: strict compare must reject it
    send_item(make_item(2'd2, 16'd4, 16'd0, 16'd2, 16'd0, 32'd5000, 32'd0));
    send_item(make_item(2'd2, 16'd0, 16'd4, 16'd0, 16'd2, 32'd5000, 32'd0));
    send_item(make_item(2'd2, 16'd3, 16'd0, 16'd2, 16'd0, 32'd5000, 32'd0));
    send_item(make_item(2'd2, -16'sd3, 16'd0, 16'd2, 16'd0, 32'd5000, 32'd0));
    send_item(make_item(2'd2, 16'd0, 16'd0, 16'd1, 16'd1, 32'd5000, 32'd0));
    wait_results_done();
  endtask

  task automatic test_field_extremes();
    set_reg(REG_Z1_REACH, 32'h0000_FFFF);
    set_reg(REG_Z1_DELAY, 32'd0);
    set_reg(REG_Z2_DELAY, 32'd0);
    set_reg(REG_Z3_DELAY, 32'd0);
    send_item(make_item(2'd0, S16_MAX, S16_MAX, S16_MAX, S16_MAX, 32'd1, 32'd0));
    send_item(make_item(2'd1, S16_MIN, S16_MIN, S16_MIN, S16_MIN, 32'd1, 32'd0));
    send_item(make_item(2'd2, S16_MAX, S16_MIN, S16_MIN, S16_MAX, 32'd1, 32'd0));
    send_item(make_item(2'd0, S16_MIN, S16_MAX, S16_MAX, S16_MIN, 32'd1, 32'd0));
    send_item(make_item(2'd1, S16_MIN, S16_MIN, S16_MAX, S16_MAX, 32'd1, 32'd0));
    send_item(make_item(2'd2, 16'd1, 16'd1, S16_MIN, S16_MIN, 32'd1, 32'd0));
    send_item(make_item(2'd0, 16'hFFFF, 16'hFFFF, S16_MIN, S16_MIN, 32'd1, 32'd0));
    // zero elapsed time never exceeds a zero delay
    send_item(make_item(2'd1, 16'hFFFF, 16'hFFFF, S16_MIN, S16_MIN, U32_MAX, U32_MAX));
    wait_results_done();
    set_reg(REG_Z1_DELAY, U32_MAX);
    set_reg(REG_Z2_DELAY, U32_MAX);
    set_reg(REG_Z3_DELAY, U32_MAX);
    send_item(make_item(2'd2, 16'hFFFF, 16'hFFFF, S16_MIN, S16_MIN, U32_MAX, 32'd0));
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    for (int s = 0; s < 4; s++) begin
      unique case (s)
        0: begin
          set_reg(REG_Z1_REACH, $urandom);
          set_reg(REG_Z2_REACH, $urandom);
          set_reg(REG_Z3_REACH, $urandom);
          set_reg(REG_Z1_DELAY, $urandom_range(0, 1000));
          set_reg(REG_Z2_DELAY, $urandom_range(0, 1000));
          set_reg(REG_Z3_DELAY, $urandom_range(0, 1000));
        end
        1: begin
          set_reg(REG_Z1_REACH, 32'h0000_FFFF);
          set_reg(REG_Z2_REACH, 32'd1);
          set_reg(REG_Z3_REACH, 32'd0);
          set_reg(REG_Z1_DELAY, 32'd0);
          set_reg(REG_Z2_DELAY, U32_MAX);
          set_reg(REG_Z3_DELAY, U32_MAX - 32'd1);
        end
        2: begin
          set_reg(REG_Z1_REACH, $urandom);
          set_reg(REG_Z2_REACH, $urandom);
          set_reg(REG_Z3_REACH, $urandom);
          set_reg(REG_Z1_DELAY, $urandom);
          set_reg(REG_Z2_DELAY, $urandom);
          set_reg(REG_Z3_DELAY, $urandom);
        end
        default: begin
          set_reg(REG_Z1_REACH, $urandom_range(256, 4096));
          set_reg(REG_Z2_REACH, $urandom_range(256, 4096));
          set_reg(REG_Z3_REACH, $urandom_range(256, 4096));
          set_reg(REG_Z1_DELAY, $urandom_range(0, 100));
          set_reg(REG_Z2_DELAY, $urandom_range(0, 100));
          set_reg(REG_Z3_DELAY, $urandom_range(0, 100));
        end
      endcase
      for (int n = 0; n < 475; n++) begin
        // redraw idling per stretch, some stretches run flat out
        if (n % 50 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 4) != 0) send_item(make_fault_item());
        else send_item(make_noise_item());
      end
      wait_results_done();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int z = 0; z < ZoneCount; z++) begin
      reach_cfg[z] = '0;
      delay_cfg[z] = '0;
    end
    for (int p = 0; p < NumPhases; p++) trip_state[p] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_reach();
    test_register_map();
    test_phase_out_of_range();
    test_elapsed_edges();
    test_circle_boundary();
    test_field_extremes();
    test_random_traffic();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
